>>> rtl/point_in_prism_area_test_assert.svh
// Assertion macros used by the top-level RTL module.
`ifndef POINT_IN_PRISM_AREA_TEST_ASSERT_SVH
`define POINT_IN_PRISM_AREA_TEST_ASSERT_SVH

`ifndef SYNTHESIS
`define PIPAT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PIPAT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PIPAT_ASSERT_IMP(lbl, ante, cons)
`define PIPAT_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> rtl/pipat_pkg.sv
package pipat_pkg;

    localparam int MAX_CORNERS = 64;
    localparam int COORD_WIDTH = 32;
    localparam int IDX_W = $clog2(MAX_CORNERS);
    localparam int CNT_W = $clog2(MAX_CORNERS + 1);
    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int PROD_W = 2 * DIFF_W;

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_TEST   = 2'd2;

    localparam logic [1:0] ST_TEST = 2'd0;
    localparam logic [1:0] ST_ACC  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic CFG_MIN_H = 1'b0;
    localparam logic CFG_MAX_H = 1'b1;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_corner;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

    typedef struct packed {
        logic    valid;
        t_coord  px;
        t_coord  py;
        t_corner ci;
        t_corner cj;
    } t_edge_in;

    function automatic t_coord to_coord(input logic [31:0] v);
        logic signed [63:0] e;
        e = 64'(signed'(v));
        return e[COORD_WIDTH-1:0];
    endfunction

endpackage

>>> rtl/pipat_cell.sv
module pipat_cell (
    input  logic                i_clk,
    input  pipat_pkg::t_cell_ctl i_ctl,
    input  pipat_pkg::t_corner  i_load,
    input  pipat_pkg::t_corner  i_next,
    output pipat_pkg::t_corner  o_corner
);

    pipat_pkg::t_corner r_corner;
    pipat_pkg::t_corner n_corner;

    always_comb begin
        n_corner = r_corner;
        if (i_ctl.load) begin
            n_corner = i_load;
        end else if (i_ctl.shift) begin
            n_corner = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_corner <= n_corner;
    end

    assign o_corner = r_corner;

endmodule

>>> rtl/pipat_edge.sv
module pipat_edge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pipat_pkg::t_edge_in i_edge,
    output logic                o_toggle
);

    logic signed [pipat_pkg::DIFF_W-1:0] r_a, r_dy, r_c, r_d;
    logic signed [pipat_pkg::DIFF_W-1:0] n_a, n_dy, n_c, n_d;
    logic signed [pipat_pkg::PROD_W-1:0] r_p1, r_p2;
    logic r_v1, r_st1, r_pos1, r_v2, r_st2, r_pos2, r_toggle;
    logic n_st, n_cross;

    always_comb begin
        n_a  = pipat_pkg::DIFF_W'(i_edge.px) - pipat_pkg::DIFF_W'(i_edge.ci.x);
        n_dy = pipat_pkg::DIFF_W'(i_edge.cj.y) - pipat_pkg::DIFF_W'(i_edge.ci.y);
        n_c  = pipat_pkg::DIFF_W'(i_edge.cj.x) - pipat_pkg::DIFF_W'(i_edge.ci.x);
        n_d  = pipat_pkg::DIFF_W'(i_edge.py) - pipat_pkg::DIFF_W'(i_edge.ci.y);
        n_st = (i_edge.ci.y > i_edge.py) != (i_edge.cj.y > i_edge.py);
        n_cross = r_pos2 ? (r_p1 < r_p2) : (r_p2 < r_p1);
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_dy   <= n_dy;
        r_c    <= n_c;
        r_d    <= n_d;
        r_st1  <= n_st;
        r_pos1 <= (n_dy != '0) && !n_dy[pipat_pkg::DIFF_W-1];
        r_p1   <= pipat_pkg::PROD_W'(r_a) * pipat_pkg::PROD_W'(r_dy);
        r_p2   <= pipat_pkg::PROD_W'(r_c) * pipat_pkg::PROD_W'(r_d);
        r_st2  <= r_st1;
        r_pos2 <= r_pos1;
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_toggle <= 1'b0;
        end else begin
            r_v1     <= i_edge.valid;
            r_v2     <= r_v1;
            r_toggle <= r_v2 && r_st2 && n_cross;
        end
    end

    assign o_toggle = r_toggle;

endmodule

>>> rtl/point_in_prism_area_test.sv
// Vertical-prism area test.
// Input channel (i_in_valid / o_in_stall) carries one request per transaction:
// clear polygon, append corner, or test point. Output channel
// (o_out_valid / i_out_stall) returns one result for append and test; clear
// and the unused code return nothing.
// Corners sit in a ring of 64 cells. A test rotates the ring once, feeding
// one edge per cycle to a single edge unit with one multiplier pair and a
// three-stage pipeline; after the walk (S_WALK) the pipeline drains
// (S_DRAIN), then the result is registered and the block returns to idle to
// take the next request. Clear and append are handled in idle; an append
// result is valid the cycle after acceptance.
// While an undelivered result is stalled at the output, no new request is
// taken. Results are held in an output register until taken.
// Configuration writes (i_cfg_valid / o_cfg_ready, always ready) set the
// min and max height; write them only while idle.
// Reset (synchronous, active low) empties the polygon, drops any pending
// result and restores the full height range.
`include "point_in_prism_area_test_assert.svh"

module point_in_prism_area_test (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic signed [31:0] i_coord_z,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_inside_res,
    output logic        o_height_ok,
    output logic        o_in_polygon,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    localparam int MC = pipat_pkg::MAX_CORNERS;
    localparam int CW = pipat_pkg::CNT_W;

    logic [1:0]          r_state;
    logic [CW-1:0]       r_count, r_step;
    logic [1:0]          r_drain;
    logic signed [31:0]  r_min_h, r_max_h;
    pipat_pkg::t_coord   r_bminx, r_bmaxx, r_bminy, r_bmaxy;
    pipat_pkg::t_coord   r_px, r_py;
    logic                r_hok, r_pre, r_odd;
    pipat_pkg::t_corner  r_first, r_prev;
    logic                r_out_valid, r_inside, r_oh, r_inp;
    logic [1:0]          r_status;

    logic                w_acc, w_full, w_hok, w_inbox, w_toggle;
    logic                w_out_set;
    pipat_pkg::t_coord   w_x, w_y;
    pipat_pkg::t_corner  w_corner [MC];
    pipat_pkg::t_corner  w_new;
    pipat_pkg::t_edge_in w_edge;
    logic                w_shift;

    assign w_x     = pipat_pkg::to_coord(i_coord_x);
    assign w_y     = pipat_pkg::to_coord(i_coord_y);
    assign w_new   = '{x: w_x, y: w_y};
    assign w_acc   = i_in_valid && !o_in_stall;
    assign w_full  = (r_count == CW'(MC));
    assign w_hok   = (r_min_h <= i_coord_z) && (i_coord_z <= r_max_h);
    assign w_inbox = (w_x >= r_bminx) && (w_x <= r_bmaxx) &&
                     (w_y >= r_bminy) && (w_y <= r_bmaxy);
    assign w_shift = (r_state == S_WALK) && (r_step < CW'(MC));
    assign w_out_set = ((r_state == S_IDLE) && w_acc &&
                        (i_req_type == pipat_pkg::REQ_APPEND)) ||
                       ((r_state == S_DRAIN) && (r_drain == 2'd3));

    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign o_cfg_ready = 1'b1;

    for (genvar k = 0; k < MC; k++) begin : g_cell
        localparam int NXT = (k + 1) % MC;
        pipat_pkg::t_cell_ctl w_ctl;
        assign w_ctl.load  = w_acc && (i_req_type == pipat_pkg::REQ_APPEND) && !w_full &&
                             (r_count[pipat_pkg::IDX_W-1:0] == pipat_pkg::IDX_W'(k));
        assign w_ctl.shift = w_shift;
        pipat_cell u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_load   (w_new),
            .i_next   (w_corner[NXT]),
            .o_corner (w_corner[k])
        );
    end

    always_comb begin
        w_edge.valid = (r_state == S_WALK) && (r_step != '0) && (r_step <= r_count);
        w_edge.px    = r_px;
        w_edge.py    = r_py;
        w_edge.ci    = (r_step == r_count) ? r_first : w_corner[0];
        w_edge.cj    = r_prev;
    end

    pipat_edge u_edge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_edge   (w_edge),
        .o_toggle (w_toggle)
    );

    always_ff @(posedge i_clk) begin
        if (w_acc && (i_req_type == pipat_pkg::REQ_APPEND) && !w_full) begin
            if (r_count == '0) begin
                r_bminx <= w_x;
                r_bmaxx <= w_x;
                r_bminy <= w_y;
                r_bmaxy <= w_y;
            end else begin
                if (w_x < r_bminx) r_bminx <= w_x;
                if (w_x > r_bmaxx) r_bmaxx <= w_x;
                if (w_y < r_bminy) r_bminy <= w_y;
                if (w_y > r_bmaxy) r_bmaxy <= w_y;
            end
        end
        if (r_state == S_WALK && r_step < CW'(MC)) begin
            if (r_step == '0) r_first <= w_corner[0];
            r_prev <= w_corner[0];
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_drain     <= '0;
            r_min_h     <= 32'sh8000_0000;
            r_max_h     <= 32'sh7FFF_FFFF;
            r_odd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    pipat_pkg::CFG_MIN_H: r_min_h <= i_cfg_data;
                    pipat_pkg::CFG_MAX_H: r_max_h <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_out_set) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_toggle) r_odd <= !r_odd;
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        case (i_req_type)
                            pipat_pkg::REQ_CLEAR: r_count <= '0;
                            pipat_pkg::REQ_APPEND: begin
                                r_inside    <= 1'b0;
                                r_oh        <= 1'b0;
                                r_inp       <= 1'b0;
                                r_status    <= w_full ? pipat_pkg::ST_FULL : pipat_pkg::ST_ACC;
                                if (!w_full) r_count <= r_count + 1'b1;
                            end
                            pipat_pkg::REQ_TEST: begin
                                r_px    <= w_x;
                                r_py    <= w_y;
                                r_hok   <= w_hok;
                                r_pre   <= w_inbox && (r_count >= CW'(2));
                                r_odd   <= 1'b0;
                                r_step  <= '0;
                                r_state <= S_WALK;
                            end
                            default: ;
                        endcase
                    end
                end
                S_WALK: begin
                    if (r_step == CW'(MC)) begin
                        r_drain <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_drain <= r_drain + 1'b1;
                    if (r_drain == 2'd3) begin
                        r_inside    <= r_hok && r_pre && r_odd;
                        r_oh        <= r_hok;
                        r_inp       <= r_pre && r_odd;
                        r_status    <= pipat_pkg::ST_TEST;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_inside_res = r_inside;
    assign o_height_ok  = r_oh;
    assign o_in_polygon = r_inp;
    assign o_status     = r_status;

    `PIPAT_ASSERT_IMP(a_busy_stalls, r_state != S_IDLE, o_in_stall)
    `PIPAT_ASSERT_IMP(a_toggle_in_test, w_toggle, r_state == S_WALK || r_state == S_DRAIN)
    `PIPAT_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CW'(MC))
    `PIPAT_ASSERT_NXT(a_test_no_early_out, r_state == S_WALK, !o_out_valid)

endmodule
